### design/salc_pkg.sv
package salc_pkg;

    // Field widths of the request and the result
    localparam int ADDR_W   = 32;
    localparam int WAY_OUT_W = 2;
    localparam int CNT_W    = 32;

    // Configuration registers
    localparam int OFFSET_W  = 3;
    localparam int SIDX_W    = 4;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = 3'd4;
    localparam logic [SIDX_W-1:0]   SIDX_RST   = 4'd8;

    // Widest set index that is ever used
    localparam int IDX_W = 8;
    localparam logic [SIDX_W-1:0] MAX_INDEX_BITS = 4'd8;

    typedef enum logic {
        REG_OFFSET_BITS    = 1'b0,
        REG_SET_INDEX_BITS = 1'b1
    } t_reg_idx;

endpackage

### design/salc_req_if.sv
interface salc_req_if;
    logic                          valid;
    logic                          ready;
    logic [salc_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

### design/salc_rsp_if.sv
interface salc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic [salc_pkg::WAY_OUT_W-1:0] way;
    logic [salc_pkg::CNT_W-1:0]     access_number;

    modport source (output valid, output hit, output way, output access_number, input ready);
    modport sink   (input valid, input hit, input way, input access_number, output ready);
endinterface

### design/set_assoc_lru_cache_tags.sv
// Tag store of a set-associative cache with true LRU replacement.
// Request channel i_req carries one byte address; response channel o_rsp
// returns hit, the way that hit or was filled (low two bits) and a running
// access number. Offset and set-index widths are set over the APB port at
// byte addresses 0 and 4; write them only while no request is in flight.
// One request is taken per cycle while results are being taken. The
// accepting edge registers the read of the set memory; the lookup stage
// then does the lookup and update into the output register, from which
// the response is valid. A set row written by the previous request is
// forwarded, so back-to-back accesses to the same set need no bubble.
// Reset clears the access count, the output valid and one flag per set;
// a set whose flag is clear reads as all ways invalid, way 0 oldest, so
// no clearing pass runs and requests are taken from the first cycle.
// When the receiver holds o_rsp.ready low the result waits in the output
// register, one more request enters the lookup stage and then i_req.ready
// drops until the result is taken.
module set_assoc_lru_cache_tags #(
    parameter int SETS      = 256,
    parameter int WAYS      = 4,
    parameter int ADDR_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    salc_req_if.sink                          i_req,
    salc_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [salc_pkg::PADDR_W-1:0]      paddr,
    input  logic [salc_pkg::PDATA_W-1:0]      pwdata,
    output logic [salc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W  = (ADDR_BITS < salc_pkg::ADDR_W) ? ADDR_BITS : salc_pkg::ADDR_W;
    localparam int ROW_W  = WAYS * (TAG_W + 1 + WAY_W);
    localparam int VLD_LO = WAYS * TAG_W;
    localparam int LRU_LO = WAYS * (TAG_W + 1);
    localparam int NTAB   = 1 << salc_pkg::IDX_W;
    localparam logic [salc_pkg::ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= salc_pkg::ADDR_W) ? {salc_pkg::ADDR_W{1'b1}} :
        salc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    // Configuration
    logic [salc_pkg::OFFSET_W-1:0] r_off;
    logic [salc_pkg::SIDX_W-1:0]   r_sidx;
    salc_pkg::t_reg_idx            reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = salc_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= salc_pkg::OFFSET_RST;
            r_sidx <= salc_pkg::SIDX_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                salc_pkg::REG_OFFSET_BITS:    r_off  <= pwdata[salc_pkg::OFFSET_W-1:0];
                salc_pkg::REG_SET_INDEX_BITS: r_sidx <= pwdata[salc_pkg::SIDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            salc_pkg::REG_OFFSET_BITS:    prdata = salc_pkg::PDATA_W'(r_off);
            salc_pkg::REG_SET_INDEX_BITS: prdata = salc_pkg::PDATA_W'(r_sidx);
            default:                      prdata = '0;
        endcase
    end

    // Set number reduced modulo SETS
    logic [SET_W-1:0] set_tab [NTAB];
    for (genvar g = 0; g < NTAB; g++) begin : g_set_tab
        assign set_tab[g] = SET_W'(g % SETS);
    end

    // Handshake and pipeline control
    logic r_s1_vld, r_out_vld;
    logic s1_adv, in_ready, in_acc;

    assign s1_adv      = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign in_ready    = !r_s1_vld || s1_adv;
    assign in_acc      = i_req.valid && in_ready;
    assign i_req.ready = in_ready;

    // Address split
    logic [salc_pkg::ADDR_W-1:0] addr_m, addr_sh, tag_full;
    logic [salc_pkg::SIDX_W-1:0] sib;
    logic [salc_pkg::IDX_W-1:0]  idx_mask, idx;
    logic [4:0]                  tag_shift;
    logic [SET_W-1:0]            s0_set;

    always_comb begin
        addr_m    = i_req.address & ADDR_MASK;
        sib       = (r_sidx > salc_pkg::MAX_INDEX_BITS) ? salc_pkg::MAX_INDEX_BITS : r_sidx;
        addr_sh   = addr_m >> r_off;
        idx_mask  = ~({salc_pkg::IDX_W{1'b1}} << sib);
        idx       = addr_sh[salc_pkg::IDX_W-1:0] & idx_mask;
        tag_shift = 5'(r_off) + 5'(sib);
        tag_full  = addr_m >> tag_shift;
        s0_set    = set_tab[idx];
    end

    logic [SET_W-1:0] r_s1_set;
    logic [TAG_W-1:0] r_s1_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_ready) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_set <= s0_set;
            r_s1_tag <= tag_full[TAG_W-1:0];
        end
    end

    // Set memory: one row holds tags, valid bits and LRU order of a set
    logic [ROW_W-1:0] r_mem [SETS];
    logic [ROW_W-1:0] r_rd_row, wr_row;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_set] <= wr_row;
        end
        if (in_acc) begin
            r_rd_row <= r_mem[s0_set];
        end
    end

    // Row-written flags and last write for forwarding
    logic [SETS-1:0]  r_init;
    logic             r_wr_vld;
    logic [SET_W-1:0] r_wr_set;
    logic [ROW_W-1:0] r_wr_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init   <= '0;
            r_wr_vld <= 1'b0;
        end else if (s1_adv) begin
            r_init[r_s1_set] <= 1'b1;
            r_wr_vld         <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_wr_set <= r_s1_set;
            r_wr_row <= wr_row;
        end
    end

    // Lookup and LRU update
    logic [ROW_W-1:0] reset_row, cur_row;
    logic [TAG_W-1:0] cur_tag [WAYS];
    logic [TAG_W-1:0] new_tag [WAYS];
    logic [WAY_W-1:0] cur_lru [WAYS];
    logic [WAY_W-1:0] new_lru [WAYS];
    logic [WAYS-1:0]  cur_vld, new_vld;
    logic             fwd, hit;
    logic [WAY_W-1:0] hit_way, use_way, pos;
    logic [31:0]      way_ext;

    always_comb begin
        reset_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            reset_row[LRU_LO + w*WAY_W +: WAY_W] = WAY_W'(w);
        end

        fwd = r_wr_vld && (r_wr_set == r_s1_set);
        if (fwd) begin
            cur_row = r_wr_row;
        end else if (r_init[r_s1_set]) begin
            cur_row = r_rd_row;
        end else begin
            cur_row = reset_row;
        end

        for (int w = 0; w < WAYS; w++) begin
            cur_tag[w] = cur_row[w*TAG_W +: TAG_W];
            cur_vld[w] = cur_row[VLD_LO + w];
            cur_lru[w] = cur_row[LRU_LO + w*WAY_W +: WAY_W];
        end

        // lowest matching way wins
        hit     = 1'b0;
        hit_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (cur_vld[w] && (cur_tag[w] == r_s1_tag)) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        use_way = hit ? hit_way : cur_lru[0];

        pos = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (cur_lru[i] == use_way) begin
                pos = WAY_W'(i);
            end
        end

        // drop use_way from its place and append it as newest
        for (int i = 0; i < WAYS - 1; i++) begin
            new_lru[i] = (i < int'(pos)) ? cur_lru[i] : cur_lru[i+1];
        end
        new_lru[WAYS-1] = use_way;

        new_vld = cur_vld;
        new_vld[use_way] = 1'b1;
        for (int w = 0; w < WAYS; w++) begin
            new_tag[w] = cur_tag[w];
        end
        if (!hit) begin
            new_tag[use_way] = r_s1_tag;
        end

        wr_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            wr_row[w*TAG_W +: TAG_W]           = new_tag[w];
            wr_row[VLD_LO + w]                 = new_vld[w];
            wr_row[LRU_LO + w*WAY_W +: WAY_W]  = new_lru[w];
        end

        way_ext = 32'(use_way);
    end

    // Access count and output register
    logic [salc_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic                           r_hit;
    logic [salc_pkg::WAY_OUT_W-1:0] r_way;
    logic [salc_pkg::CNT_W-1:0]     r_num;

    assign n_cnt = r_cnt + salc_pkg::CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_cnt     <= n_cnt;
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_hit <= hit;
            r_way <= way_ext[salc_pkg::WAY_OUT_W-1:0];
            r_num <= n_cnt;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.way           = r_way;
    assign o_rsp.access_number = r_num;

`ifndef NO_ASSERTIONS
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> (r_cnt == $past(n_cnt)))
        else $error("access count did not advance by one");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_vld && r_out_vld && !o_rsp.ready))
        else $error("request side stalled without a held result");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && hit) |-> cur_vld[hit_way])
        else $error("hit reported on an invalid way");
`endif

endmodule
